### hdl/tpe_pkg.sv
`default_nettype none
package tpe_pkg;

  localparam int QW = 32;
  localparam int OW = 48;
  localparam int NOUT = 10;
  localparam int ACCW = 64;
  localparam logic signed [QW-1:0] ONE_Q = 32'sh0100_0000;

  typedef enum logic [1:0] {
    MODE_EVAL = 2'd0,
    MODE_ALPHA = 2'd1,
    MODE_BETA = 2'd2,
    MODE_WEIGHT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DEG_X = 2'd0,
    REG_DEG_Y = 2'd1,
    REG_DEG_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BINIT,
    ST_BRD,
    ST_BT,
    ST_BM,
    ST_BWR,
    ST_SUM_RD,
    ST_SUM_F,
    ST_SUM_P1,
    ST_SUM_P2,
    ST_SUM_W,
    ST_DONE
  } state_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] hi;
    logic signed [ACCW-1:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[QW-1:0];
  endfunction

  function automatic logic signed [ACCW-1:0] rnd24(input logic signed [ACCW-1:0] p);
    logic signed [ACCW-1:0] q;
    q = p + 64'sd8388608;
    return q >>> 24;
  endfunction

  function automatic logic signed [OW-1:0] sat48(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] hi;
    logic signed [ACCW-1:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -64'sh0000_8000_0000_0000;
    if (v > hi) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < lo) begin
      return 48'sh8000_0000_0000;
    end
    return v[OW-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/tpe_ram.sv
`default_nettype none
module tpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/tpe_mulq.sv
`default_nettype none
module tpe_mulq
  import tpe_pkg::*;
(
  input wire logic clk,
  input wire logic signed [QW-1:0] a,
  input wire logic signed [QW-1:0] b,
  output logic signed [ACCW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= ACCW'(a) * ACCW'(b);
  end

endmodule
`default_nettype wire

### hdl/tensor_orthopoly_eval.sv
`default_nettype none
// Channel  | Direction | Signals
// command  | in, out   | start, mode, dim_select, table_index, coeff_value, coord_x/y/z (in); busy (out)
// config   | in        | cfg_we, cfg_index, cfg_data
// result   | out       | result_valid, value, d_dx .. d2_zz
// An evaluation first builds the basis tables, then sums (dx+1)(dy+1)(dz+1) terms in turn,
// with its pace set by the single shared multiplier and the one read port of the weight and
// basis memories.
// Reset clears the control state and the degree registers; tables are undefined until written.
// busy is high while an evaluation runs and falls in the cycle of the result strobe; the
// result strobe cannot be stalled.
module tensor_orthopoly_eval
  import tpe_pkg::*;
#(
  parameter int DIMS = 3,
  parameter int MAX_DEGREE = 15
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [3:0] cfg_data,
  input wire logic [1:0] mode,
  input wire logic [1:0] dim_select,
  input wire logic [11:0] table_index,
  input wire logic signed [31:0] coeff_value,
  input wire logic signed [31:0] coord_x,
  input wire logic signed [31:0] coord_y,
  input wire logic signed [31:0] coord_z,
  output logic result_valid,
  output logic signed [47:0] value,
  output logic signed [47:0] d_dx,
  output logic signed [47:0] d_dy,
  output logic signed [47:0] d_dz,
  output logic signed [47:0] d2_xx,
  output logic signed [47:0] d2_xy,
  output logic signed [47:0] d2_xz,
  output logic signed [47:0] d2_yy,
  output logic signed [47:0] d2_yz,
  output logic signed [47:0] d2_zz
);

  localparam int NDEG = MAX_DEGREE + 1;
  localparam int TDEPTH = 3 * NDEG;
  localparam int WDEPTH = NDEG * NDEG * NDEG;
  localparam int TAW = $clog2(TDEPTH);
  localparam int WAW = $clog2(WDEPTH);
  localparam int DW = $clog2(NDEG + 1);
  localparam int BW = 3 * QW;

  logic [3:0] degree_x, degree_y, degree_z;
  state_t state, state_next;

  logic [1:0] dsel;
  logic [DW-1:0] jcnt;
  logic [DW-1:0] mdeg [3];
  logic signed [QW-1:0] xcoord [3];
  logic signed [QW-1:0] tval, bval;
  logic signed [QW-1:0] f1, df1, dd1, f2, df2, dd2;
  logic [2:0] sub;
  logic signed [ACCW-1:0] part;

  logic a_we, b_we, w_we, bs_we;
  logic [TAW-1:0] ab_waddr, ab_raddr, bs_waddr, bs_raddr;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [QW-1:0] a_rd, b_rd, w_rd;
  logic [BW-1:0] bs_wdata, bs_rd;

  logic signed [QW-1:0] ma, mb;
  logic signed [ACCW-1:0] mp;

  logic [DW-1:0] ii, jj, kk;
  logic [WAW-1:0] widx;
  logic signed [QW-1:0] fx, dfx, ddx, fy, dfy, ddy, fz, dfz, ddz;
  logic [3:0] nsel;
  logic [1:0] ph;
  logic signed [QW-1:0] tprod;
  logic signed [ACCW-1:0] acc [NOUT];
  logic signed [QW-1:0] wreg;

  function automatic logic [DW-1:0] clampdeg(input logic [3:0] r, input int d);
    if (d >= DIMS) begin
      return '0;
    end else if (int'(r) > MAX_DEGREE) begin
      return DW'(MAX_DEGREE);
    end
    return DW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_x <= '0;
      degree_y <= '0;
      degree_z <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DEG_X: degree_x <= cfg_data;
        REG_DEG_Y: degree_y <= cfg_data;
        REG_DEG_Z: degree_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic acc_cmd, wr_ab_ok;
  assign acc_cmd = start && !busy;
  assign wr_ab_ok = (int'(dim_select) < DIMS) && (int'(table_index) <= MAX_DEGREE);
  assign a_we = acc_cmd && mode_t'(mode) == MODE_ALPHA && wr_ab_ok;
  assign b_we = acc_cmd && mode_t'(mode) == MODE_BETA && wr_ab_ok;
  assign w_we = acc_cmd && mode_t'(mode) == MODE_WEIGHT && int'(table_index) < WDEPTH;
  assign ab_waddr = TAW'(int'(dim_select) * NDEG + int'(table_index));
  assign w_waddr = WAW'(table_index);
  assign ab_raddr = TAW'(int'(dsel) * NDEG + int'(jcnt) - 1);

  tpe_ram #(.WIDTH(QW), .DEPTH(TDEPTH)) u_alpha (
    .clk(clk), .we(a_we), .waddr(ab_waddr), .wdata(coeff_value),
    .raddr(ab_raddr), .rdata(a_rd));
  tpe_ram #(.WIDTH(QW), .DEPTH(TDEPTH)) u_beta (
    .clk(clk), .we(b_we), .waddr(ab_waddr), .wdata(coeff_value),
    .raddr(ab_raddr), .rdata(b_rd));
  tpe_ram #(.WIDTH(QW), .DEPTH(WDEPTH)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(coeff_value),
    .raddr(w_raddr), .rdata(w_rd));
  tpe_ram #(.WIDTH(BW), .DEPTH(TDEPTH)) u_basis (
    .clk(clk), .we(bs_we), .waddr(bs_waddr), .wdata(bs_wdata),
    .raddr(bs_raddr), .rdata(bs_rd));

  tpe_mulq u_mul (.clk(clk), .a(ma), .b(mb), .prod(mp));

  logic signed [QW-1:0] mq;
  assign mq = sat32(rnd24(mp));

  assign bs_we = (state == ST_BINIT) || (state == ST_BWR);
  assign bs_waddr = TAW'(int'(dsel) * NDEG + int'(jcnt));
  always_comb begin
    bs_wdata = {s3[QW-1:0], tprod, wreg};
    if (state == ST_BINIT) begin
      bs_wdata = {ONE_Q, {QW{1'b0}}, {QW{1'b0}}};
    end else if (jcnt == DW'(1)) begin
      bs_wdata = {tval, ONE_Q, {QW{1'b0}}};
    end
  end

  always_comb begin
    widx = WAW'(int'(ii) + (int'(mdeg[0]) + 1) * (int'(jj) + (int'(mdeg[1]) + 1) * int'(kk)));
  end
  assign w_raddr = widx;
  always_comb begin
    bs_raddr = TAW'(int'(ii));
    case (sub)
      3'd1: bs_raddr = TAW'(NDEG + int'(jj));
      3'd2: bs_raddr = TAW'(2 * NDEG + int'(kk));
      default: ;
    endcase
  end

  always_comb begin
    ma = tval;
    mb = f1;
    if (state == ST_BM) begin
      case (sub)
        3'd0: begin ma = tval; mb = f1; end
        3'd1: begin ma = bval; mb = f2; end
        3'd2: begin ma = tval; mb = df1; end
        3'd3: begin ma = bval; mb = df2; end
        3'd4: begin ma = tval; mb = dd1; end
        default: begin ma = bval; mb = dd2; end
      endcase
    end else if (state == ST_SUM_P1) begin
      case (nsel)
        4'd1, 4'd6: begin ma = dfx; mb = fy; end
        4'd2, 4'd8: begin ma = fx; mb = dfy; end
        4'd4: begin ma = ddx; mb = fy; end
        4'd5: begin ma = dfx; mb = dfy; end
        4'd7: begin ma = fx; mb = ddy; end
        default: begin ma = fx; mb = fy; end
      endcase
    end else if (state == ST_SUM_P2) begin
      ma = tprod;
      case (nsel)
        4'd3, 4'd6, 4'd8: mb = dfz;
        4'd9: mb = ddz;
        default: mb = fz;
      endcase
    end else begin
      ma = tprod;
      mb = wreg;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc_cmd && mode_t'(mode) == MODE_EVAL) state_next = ST_BINIT;
      ST_BINIT: begin
        if (jcnt != mdeg[dsel]) begin
          state_next = ST_BRD;
        end else if (dsel == 2'd2) begin
          state_next = ST_SUM_RD;
        end else begin
          state_next = ST_BINIT;
        end
      end
      ST_BRD: state_next = ST_BT;
      ST_BT: state_next = ST_BM;
      ST_BM: if (sub == 3'd6) state_next = ST_BWR;
      ST_BWR: state_next = ST_BRD;
      ST_SUM_RD: state_next = ST_SUM_F;
      ST_SUM_F: if (sub == 3'd3) state_next = ST_SUM_P1;
      ST_SUM_P1: if (ph == 2'd1) state_next = ST_SUM_P2;
      ST_SUM_P2: if (ph == 2'd1) state_next = ST_SUM_W;
      ST_SUM_W: begin
        if (ph == 2'd1) begin
          if (nsel != 4'(NOUT - 1)) begin
            state_next = ST_SUM_P1;
          end else if (ii == mdeg[0] && jj == mdeg[1] && kk == mdeg[2]) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SUM_RD;
          end
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_BWR && jcnt == mdeg[dsel]) begin
      state_next = (dsel == 2'd2) ? ST_SUM_RD : ST_BINIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic signed [ACCW-1:0] s3;
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_DONE);
    end
    case (state)
      ST_IDLE: begin
        dsel <= '0;
        jcnt <= '0;
        sub <= '0;
        mdeg[0] <= clampdeg(degree_x, 0);
        mdeg[1] <= clampdeg(degree_y, 1);
        mdeg[2] <= clampdeg(degree_z, 2);
        xcoord[0] <= coord_x;
        xcoord[1] <= coord_y;
        xcoord[2] <= coord_z;
        ii <= '0;
        jj <= '0;
        kk <= '0;
        for (int n = 0; n < NOUT; n++) begin
          acc[n] <= '0;
        end
      end
      ST_BINIT: begin
        f2 <= ONE_Q;
        df2 <= '0;
        dd2 <= '0;
        f1 <= ONE_Q;
        df1 <= '0;
        dd1 <= '0;
        if (jcnt == mdeg[dsel]) begin
          sub <= '0;
          dsel <= dsel + 1'b1;
        end else begin
          jcnt <= jcnt + 1'b1;
        end
      end
      ST_BT: begin
        tval <= sat32(ACCW'(xcoord[dsel]) - ACCW'($signed(a_rd)));
        bval <= (jcnt == DW'(1)) ? '0 : $signed(b_rd);
        sub <= '0;
      end
      ST_BM: begin
        sub <= sub + 1'b1;
        case (sub)
          3'd1: part <= ACCW'(mq);
          3'd2: part <= part - ACCW'(mq);
          3'd3: part <= ACCW'(f1) + ACCW'(mq);
          3'd4: part <= part - ACCW'(mq);
          3'd5: part <= ACCW'(mq);
          default: ;
        endcase
        if (sub == 3'd2) begin
          s3 <= ACCW'(sat32(part - ACCW'(mq)));
        end
        if (sub == 3'd4) begin
          tprod <= sat32(part - ACCW'(mq));
        end
        if (sub == 3'd6) begin
          wreg <= sat32(ACCW'(df1) + ACCW'(df1) + part - ACCW'(mq));
        end
      end
      ST_BWR: begin
        f2 <= f1;
        df2 <= df1;
        dd2 <= dd1;
        if (jcnt == DW'(1)) begin
          f1 <= sat32(ACCW'(xcoord[dsel]) - ACCW'($signed(a_rd)));
          df1 <= ONE_Q;
          dd1 <= '0;
        end else begin
          f1 <= s3[QW-1:0];
          df1 <= tprod;
          dd1 <= wreg;
        end
        if (jcnt == mdeg[dsel]) begin
          dsel <= dsel + 1'b1;
          jcnt <= '0;
        end else begin
          jcnt <= jcnt + 1'b1;
        end
        sub <= '0;
      end
      ST_SUM_RD: begin
        sub <= '0;
        nsel <= '0;
        ph <= '0;
      end
      ST_SUM_F: begin
        sub <= sub + 1'b1;
        case (sub)
          3'd0: wreg <= $signed(w_rd);
          3'd1: {fx, dfx, ddx} <= bs_rd;
          3'd2: {fy, dfy, ddy} <= bs_rd;
          default: {fz, dfz, ddz} <= bs_rd;
        endcase
      end
      ST_SUM_P1: begin
        if (ph == 2'd1) begin
          tprod <= mq;
          ph <= '0;
        end else begin
          ph <= ph + 1'b1;
        end
      end
      ST_SUM_P2: begin
        if (ph == 2'd1) begin
          tprod <= mq;
          ph <= '0;
        end else begin
          ph <= ph + 1'b1;
        end
      end
      ST_SUM_W: begin
        if (ph == 2'd1) begin
          acc[nsel] <= acc[nsel] + rnd24(mp);
          ph <= '0;
          if (nsel != 4'(NOUT - 1)) begin
            nsel <= nsel + 1'b1;
          end else if (ii != mdeg[0]) begin
            ii <= ii + 1'b1;
          end else if (jj != mdeg[1]) begin
            ii <= '0;
            jj <= jj + 1'b1;
          end else begin
            ii <= '0;
            jj <= '0;
            kk <= kk + 1'b1;
          end
        end else begin
          ph <= ph + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      value <= sat48(acc[0]);
      d_dx <= sat48(acc[1]);
      d_dy <= sat48(acc[2]);
      d_dz <= sat48(acc[3]);
      d2_xx <= sat48(acc[4]);
      d2_xy <= sat48(acc[5]);
      d2_xz <= sat48(acc[6]);
      d2_yy <= sat48(acc[7]);
      d2_yz <= sat48(acc[8]);
      d2_zz <= sat48(acc[9]);
    end
  end

  assign busy = (state != ST_IDLE);

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_DONE)) else $error("result without done");
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("busy after result");
  a_no_wr_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(a_we || b_we || w_we)) else $error("write while busy");

endmodule
`default_nettype wire
